>>> hdl/integer_to_ascii_formatter_defines.svh
// Assertion macros for the integer to ASCII formatter.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

`ifndef SYNTHESIS
`define ITAF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ITAF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ITAF_ASSERT(lbl, clk, rst, prop, msg)
`define ITAF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> hdl/itaf_pkg.sv
// Shared types, character codes and helpers for the integer to ASCII formatter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itaf_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS_DEF = 32;
  localparam int COUNT_W        = 6;
  localparam int LEN_W          = 7;
  localparam int WIDTH_W        = 6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2,
    BASE_HEX = 2'd3
  } base_t;

  typedef struct packed {
    logic                 is_negative;
    base_t                base;
    logic                 show_prefix;
    logic                 zero_pad;
    logic [WIDTH_W-1:0]   pad_width;
  } item_opts_t;

  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] count;
    logic [3:0]         digit;
  } conv_status_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return 8'h30 + {4'h0, d};
    end
    return 8'h57 + {4'h0, d};
  endfunction

  function automatic logic [7:0] prefix_char(input base_t b);
    logic [7:0] c;
    case (b)
      BASE_BIN: c = 8'h62;
      BASE_OCT: c = 8'h6f;
      default:  c = 8'h78;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/itaf_item_if.sv
// Input channel: one integer with its format options per beat.
// Uses itaf_pkg for nothing but shares its width conventions.
`timescale 1ns / 1ps
`default_nettype none

interface itaf_item_if #(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  is_negative;
  logic [1:0]            base_select;
  logic                  show_prefix;
  logic                  zero_pad;
  logic [5:0]            pad_width;

  modport source (
    output valid, value, is_negative, base_select, show_prefix, zero_pad, pad_width,
    input  ready
  );
  modport sink (
    input  valid, value, is_negative, base_select, show_prefix, zero_pad, pad_width,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/itaf_text_if.sv
// Output channel: one ASCII character per beat, last marks the end of a run.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface itaf_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

>>> hdl/itaf_convert.sv
// Digit unit: one shared shift/adjust register turns the magnitude into digits,
// most significant digit left at the top nibble. Depends on itaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itaf_convert #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [VALUE_BITS-1:0]   value,
  input  wire itaf_pkg::item_opts_t    opts,
  input  wire logic                    pop,
  output itaf_pkg::conv_status_t       status
);
  import itaf_pkg::*;

  localparam int DW    = 4 * MAX_DIGITS;
  localparam int BIT_W = $clog2(VALUE_BITS + 1);

  typedef enum logic [4:0] {
    C_IDLE  = 5'b00001,
    C_POW2  = 5'b00010,
    C_DEC   = 5'b00100,
    C_ALIGN = 5'b01000,
    C_HOLD  = 5'b10000
  } conv_state_t;

  conv_state_t           state;
  logic [VALUE_BITS-1:0] rem;
  logic [DW-1:0]         digits;
  logic [COUNT_W-1:0]    count;
  logic [BIT_W-1:0]      bits_left;
  logic                  sticky;
  base_t                 base;

  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] rem_shr;
  logic [3:0]            pow_digit;
  logic [DW-1:0]         adj;
  logic [3:0]            top_nib;

  assign mag     = opts.is_negative ? (~value + VALUE_BITS'(1)) : value;
  assign top_nib = digits[DW-1 -: 4];

  always_comb begin
    case (base)
      BASE_BIN: begin
        rem_shr   = rem >> 1;
        pow_digit = {3'b000, rem[0]};
      end
      BASE_OCT: begin
        rem_shr   = rem >> 3;
        pow_digit = {1'b0, rem[2:0]};
      end
      default: begin
        rem_shr   = rem >> 4;
        pow_digit = rem[3:0];
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[4*i +: 4] = (digits[4*i +: 4] >= 4'd5) ? digits[4*i +: 4] + 4'd3
                                                   : digits[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_IDLE;
      count     <= '0;
      rem       <= '0;
      bits_left <= '0;
      sticky    <= 1'b0;
      base      <= BASE_BIN;
    end else if (start) begin
      rem       <= mag;
      base      <= opts.base;
      count     <= '0;
      sticky    <= 1'b0;
      bits_left <= BIT_W'(VALUE_BITS);
      if (opts.base == BASE_DEC) begin
        digits <= '0;
        state  <= C_DEC;
      end else begin
        state  <= C_POW2;
      end
    end else begin
      unique case (state)
        C_POW2: begin
          digits <= {pow_digit, digits[DW-1:4]};
          rem    <= rem_shr;
          count  <= count + COUNT_W'(1);
          if (rem_shr == '0 || count == COUNT_W'(MAX_DIGITS - 1)) begin
            state <= C_HOLD;
          end
        end
        C_DEC: begin
          digits    <= {adj[DW-2:0], rem[VALUE_BITS-1]};
          rem       <= rem << 1;
          sticky    <= sticky | adj[DW-1];
          bits_left <= bits_left - BIT_W'(1);
          if (bits_left == BIT_W'(1)) begin
            count <= COUNT_W'(MAX_DIGITS);
            state <= C_ALIGN;
          end
        end
        C_ALIGN: begin
          if (sticky || count == COUNT_W'(1) || top_nib != 4'h0) begin
            state <= C_HOLD;
          end else begin
            digits <= {digits[DW-5:0], 4'h0};
            count  <= count - COUNT_W'(1);
          end
        end
        C_HOLD: begin
          if (pop) begin
            digits <= {digits[DW-5:0], 4'h0};
          end
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

  assign status.done  = (state == C_HOLD);
  assign status.count = count;
  assign status.digit = top_nib;

endmodule

`default_nettype wire

>>> hdl/itaf_emit.sv
// Character sequencer: pads, sign, prefix and digits, one beat per cycle
// unless stalled, via an output register. Uses itaf_pkg, itaf_text_if.
`timescale 1ns / 1ps
`default_nettype none

module itaf_emit (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire itaf_pkg::item_opts_t   opts,
  input  wire itaf_pkg::conv_status_t status,
  output logic                        pop,
  output logic                        idle,
  itaf_text_if.source                 text
);
  import itaf_pkg::*;

  typedef enum logic [7:0] {
    E_IDLE  = 8'b00000001,
    E_WAIT  = 8'b00000010,
    E_SPACE = 8'b00000100,
    E_SIGN  = 8'b00001000,
    E_PFX0  = 8'b00010000,
    E_PFXL  = 8'b00100000,
    E_ZERO  = 8'b01000000,
    E_DIGIT = 8'b10000000
  } emit_state_t;

  emit_state_t        state;
  logic               neg;
  base_t              base;
  logic               pfx;
  logic               zpad;
  logic [WIDTH_W-1:0] width;
  logic [WIDTH_W-1:0] pad_cnt;
  logic [COUNT_W-1:0] dig_left;
  logic               out_valid;
  logic [7:0]         out_byte;
  logic               out_last;

  logic [LEN_W-1:0]   body;
  logic [WIDTH_W-1:0] pad_calc;
  logic [WIDTH_W-1:0] pad_src;
  logic               adv;
  logic               char_state;
  logic [7:0]         char_next;
  emit_state_t        f_space;
  emit_state_t        f_sign;
  emit_state_t        f_pfx;
  emit_state_t        f_zero;

  assign body = LEN_W'(neg) + (pfx ? LEN_W'(2) : LEN_W'(0)) + LEN_W'(status.count);
  assign pad_calc = ({1'b0, width} > body) ? WIDTH_W'({1'b0, width} - body) : '0;
  assign pad_src  = (state == E_WAIT) ? pad_calc : pad_cnt;

  assign f_zero  = (zpad && pad_src != '0) ? E_ZERO : E_DIGIT;
  assign f_pfx   = pfx ? E_PFX0 : f_zero;
  assign f_sign  = neg ? E_SIGN : f_pfx;
  assign f_space = (!zpad && pad_src != '0) ? E_SPACE : f_sign;

  assign adv = !out_valid || text.ready;
  assign char_state = (state == E_SPACE) || (state == E_SIGN) || (state == E_PFX0) ||
                      (state == E_PFXL) || (state == E_ZERO) || (state == E_DIGIT);
  assign pop  = adv && (state == E_DIGIT);
  assign idle = (state == E_IDLE);

  always_comb begin
    unique case (state)
      E_SPACE: char_next = CH_SPACE;
      E_SIGN:  char_next = CH_MINUS;
      E_PFX0:  char_next = CH_ZERO;
      E_PFXL:  char_next = prefix_char(base);
      E_ZERO:  char_next = CH_ZERO;
      E_DIGIT: char_next = digit_char(status.digit);
      default: char_next = CH_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      out_valid <= 1'b0;
      pad_cnt   <= '0;
      dig_left  <= '0;
    end else begin
      if (adv) begin
        out_valid <= char_state;
      end
      if (adv && char_state) begin
        out_byte <= char_next;
        out_last <= (state == E_DIGIT) && (dig_left == COUNT_W'(1));
      end
      unique case (state)
        E_IDLE: begin
          if (start) begin
            neg   <= opts.is_negative;
            base  <= opts.base;
            pfx   <= opts.show_prefix && (opts.base != BASE_DEC);
            zpad  <= opts.zero_pad;
            width <= opts.pad_width;
            state <= E_WAIT;
          end
        end
        E_WAIT: begin
          if (status.done) begin
            pad_cnt  <= pad_calc;
            dig_left <= status.count;
            state    <= f_space;
          end
        end
        E_SPACE: begin
          if (adv) begin
            pad_cnt <= pad_cnt - WIDTH_W'(1);
            if (pad_cnt == WIDTH_W'(1)) begin
              state <= f_sign;
            end
          end
        end
        E_SIGN: begin
          if (adv) begin
            state <= f_pfx;
          end
        end
        E_PFX0: begin
          if (adv) begin
            state <= E_PFXL;
          end
        end
        E_PFXL: begin
          if (adv) begin
            state <= f_zero;
          end
        end
        E_ZERO: begin
          if (adv) begin
            pad_cnt <= pad_cnt - WIDTH_W'(1);
            if (pad_cnt == WIDTH_W'(1)) begin
              state <= E_DIGIT;
            end
          end
        end
        E_DIGIT: begin
          if (adv) begin
            dig_left <= dig_left - COUNT_W'(1);
            if (dig_left == COUNT_W'(1)) begin
              state <= E_IDLE;
            end
          end
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

  assign text.valid    = out_valid;
  assign text.out_byte = out_byte;
  assign text.last     = out_last;

endmodule

`default_nettype wire

>>> hdl/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter: digit unit plus character sequencer.
// Depends on itaf_pkg, itaf_item_if, itaf_text_if, itaf_convert, itaf_emit.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_ascii_formatter_defines.svh"

// One item in, one run of ASCII characters out, one character per beat with
// last on the final one. The block takes one item at a time; ready rises again
// once the final character has been loaded into the output register, so the
// next item may enter while that character still waits. Digits come from one
// shared shift register: bases 2, 8 and 16 shift out one digit at a time, while
// decimal shifts in every bit of the magnitude with a shift-and-adjust step and
// then trims leading zero digit positions one at a time (MAX_DIGITS minus the
// digit count). After that the run streams at one character per cycle while
// the sink is ready.
module integer_to_ascii_formatter #(
  parameter int VALUE_BITS = itaf_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = itaf_pkg::MAX_DIGITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  itaf_item_if.sink   item,
  itaf_text_if.source text
);
  import itaf_pkg::*;

  logic         start;
  logic         pop;
  logic         idle;
  item_opts_t   opts;
  conv_status_t status;

  assign opts.is_negative = item.is_negative;
  assign opts.base        = base_t'(item.base_select);
  assign opts.show_prefix = item.show_prefix;
  assign opts.zero_pad    = item.zero_pad;
  assign opts.pad_width   = item.pad_width;

  assign item.ready = idle;
  assign start      = item.valid && idle;

  itaf_convert #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_convert (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .value  (item.value),
    .opts   (opts),
    .pop    (pop),
    .status (status)
  );

  itaf_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opts   (opts),
    .status (status),
    .pop    (pop),
    .idle   (idle),
    .text   (text)
  );

  `ITAF_ASSERT(a_busy_after_accept, clk, rst, start |=> !item.ready, "ready high after accept")
  `ITAF_ASSERT(a_only_last_pending, clk, rst, start |-> !(text.valid && !text.last), "item accepted mid run")
  `ITAF_ASSERT(a_count_range, clk, rst, status.done |-> (status.count != '0 && status.count <= COUNT_W'(MAX_DIGITS)), "digit count out of range")
  `ITAF_ASSERT(a_pop_when_done, clk, rst, pop |-> status.done, "digit taken before conversion done")

endmodule

`default_nettype wire

>>> bench/tb_integer_to_ascii_formatter.sv
// Self-checking bench for integer_to_ascii_formatter: directed and random items, each
// expanded into its expected ASCII beats and compared with the output stream.
// Depends on itaf_pkg, itaf_item_if, itaf_text_if and the formatter RTL.
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter;
  import itaf_pkg::*;

  localparam int VALUE_BITS   = VALUE_BITS_DEF;
  localparam int MAX_DIGITS   = MAX_DIGITS_DEF;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 100;
  localparam int PHASE_ITEMS  = 110;
  localparam int SQUEEZE_ITEMS = 12;

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_O = 8'h6f;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  neg;
    base_t                 base;
    logic                  pfx;
    logic                  zpad;
    logic [5:0]            width;
  } fmt_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  logic clk;
  logic rst;

  itaf_item_if #(.VALUE_BITS(VALUE_BITS)) item_ch ();
  itaf_text_if text_ch ();

  integer_to_ascii_formatter #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .text(text_ch)
  );

  fmt_item_t  pending_items[$];
  char_beat_t expected_text[$];
  fmt_item_t  next_item;
  logic       item_fire;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_trigger;
  int         hold_seen;
  int         hold_left;
  int         quiet_cycles;
  int         mismatch_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: mismatch on %s: got %02h, want %02h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic void format_expected(input fmt_item_t it);
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] radix;
    logic [3:0]            digits[MAX_DIGITS];
    logic [7:0]            line[$];
    logic                  use_prefix;
    int                    ndig;
    int                    body;
    int                    pad;
    mag = it.neg ? (~it.value + 1'b1) : it.value;
    case (it.base)
      BASE_BIN: radix = VALUE_BITS'(2);
      BASE_OCT: radix = VALUE_BITS'(8);
      BASE_DEC: radix = VALUE_BITS'(10);
      default:  radix = VALUE_BITS'(16);
    endcase
    use_prefix = it.pfx && (it.base != BASE_DEC);
    ndig = 0;
    if (mag == 0) begin
      digits[0] = 4'd0;
      ndig = 1;
    end else begin
      while (mag != 0 && ndig < MAX_DIGITS) begin
        digits[ndig] = 4'(mag % radix);
        mag = mag / radix;
        ndig++;
      end
    end
    body = ndig + (it.neg ? 1 : 0) + (use_prefix ? 2 : 0);
    pad = (body < int'(it.width)) ? int'(it.width) - body : 0;
    if (!it.zpad) repeat (pad) line.push_back(CH_SPACE);
    if (it.neg) line.push_back(CH_MINUS);
    if (use_prefix) begin
      line.push_back(CH_ZERO);
      case (it.base)
        BASE_BIN: line.push_back(CH_LOWER_B);
        BASE_OCT: line.push_back(CH_LOWER_O);
        default:  line.push_back(CH_LOWER_X);
      endcase
    end
    if (it.zpad) repeat (pad) line.push_back(CH_ZERO);
    for (int i = ndig - 1; i >= 0; i--) begin
      line.push_back((digits[i] < 4'd10) ? CH_ZERO + 8'(digits[i])
                                         : CH_LOWER_A + 8'(digits[i]) - 8'd10);
    end
    foreach (line[i]) begin
      if (i < 63) begin
        expected_text.push_back('{ch: line[i],
                                  last: (i == line.size() - 1) || (i == 62)});
      end
    end
  endfunction

  // accept side: predict on every item beat, check every text beat
  always @(posedge clk) begin : monitor
    char_beat_t want;
    if (rst) begin
      item_fire <= 1'b0;
    end else begin
      item_fire <= item_ch.valid && item_ch.ready;
      if (item_ch.valid && item_ch.ready) begin
        format_expected('{value: item_ch.value, neg: item_ch.is_negative,
                          base: base_t'(item_ch.base_select), pfx: item_ch.show_prefix,
                          zpad: item_ch.zero_pad, width: item_ch.pad_width});
      end
      if (text_ch.valid && text_ch.ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch("unexpected beat", text_ch.out_byte, 8'h00);
        end else begin
          want = expected_text.pop_front();
          if (text_ch.out_byte !== want.ch) begin
            report_mismatch("out_byte", text_ch.out_byte, want.ch);
          end
          if (text_ch.last !== want.last) begin
            report_mismatch("last", 8'(text_ch.last), 8'(want.last));
          end
        end
      end
    end
  end

  // drive item beats from the pending queue
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_fire) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_items.pop_front();
        item_ch.valid       <= 1'b1;
        item_ch.value       <= next_item.value;
        item_ch.is_negative <= next_item.neg;
        item_ch.base_select <= next_item.base;
        item_ch.show_prefix <= next_item.pfx;
        item_ch.zero_pad    <= next_item.zpad;
        item_ch.pad_width   <= next_item.width;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // text sink: random stalls, plus a long hold when triggered
  always @(negedge clk) begin
    if (rst) begin
      text_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      text_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_trigger) begin
      text_ch.ready <= 1'b0;
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
    end else begin
      text_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (text_ch.valid && text_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat accepted in %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(input logic [VALUE_BITS-1:0] value, input logic neg,
                            input base_t base, input logic pfx, input logic zpad,
                            input logic [5:0] width);
    pending_items.push_back('{value: value, neg: neg, base: base, pfx: pfx,
                              zpad: zpad, width: width});
  endtask

  function automatic fmt_item_t random_item();
    fmt_item_t it;
    case ($urandom_range(9))
      0, 1, 2, 3: it.value = VALUE_BITS'($urandom());
      4:          it.value = VALUE_BITS'($urandom_range(15));
      5:          it.value = '0;
      6:          it.value = $urandom_range(1) ? {1'b1, {(VALUE_BITS-1){1'b0}}} : '1;
      7:          it.value = VALUE_BITS'(1) << $urandom_range(VALUE_BITS - 1);
      default:    it.value = VALUE_BITS'($urandom_range(99999));
    endcase
    it.neg  = 1'($urandom_range(1));
    it.base = base_t'($urandom_range(3));
    it.pfx  = 1'($urandom_range(1));
    it.zpad = 1'($urandom_range(1));
    case ($urandom_range(7))
      0:       it.width = 6'd63;
      1, 2:    it.width = 6'($urandom_range(63));
      default: it.width = 6'($urandom_range(20));
    endcase
    return it;
  endfunction

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || item_ch.valid || expected_text.size() != 0);
  endtask

  task automatic run_random(input int count, input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) pending_items.push_back(random_item());
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.value = '0;
    item_ch.is_negative = 1'b0;
    item_ch.base_select = 2'd0;
    item_ch.show_prefix = 1'b0;
    item_ch.zero_pad = 1'b0;
    item_ch.pad_width = 6'd0;
    text_ch.ready = 1'b0;
    item_fire = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_trigger = 0;
    hold_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
    mismatch_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    queue_item('0, 1'b0, BASE_DEC, 1'b0, 1'b0, 6'd0);
    queue_item('0, 1'b1, BASE_DEC, 1'b0, 1'b0, 6'd0);
    queue_item(32'h8000_0000, 1'b1, BASE_DEC, 1'b0, 1'b0, 6'd0);
    queue_item(32'h8000_0000, 1'b1, BASE_HEX, 1'b1, 1'b1, 6'd12);
    queue_item('1, 1'b0, BASE_BIN, 1'b1, 1'b0, 6'd0);
    queue_item('1, 1'b1, BASE_BIN, 1'b1, 1'b0, 6'd0);
    queue_item('1, 1'b0, BASE_OCT, 1'b1, 1'b0, 6'd0);
    queue_item('1, 1'b0, BASE_DEC, 1'b1, 1'b0, 6'd0);
    queue_item(32'hdead_beef, 1'b0, BASE_HEX, 1'b1, 1'b0, 6'd0);
    queue_item(32'h0123_4567, 1'b0, BASE_HEX, 1'b0, 1'b0, 6'd8);
    queue_item(32'd12345, 1'b1, BASE_DEC, 1'b1, 1'b1, 6'd10);
    queue_item(32'd12345, 1'b1, BASE_DEC, 1'b0, 1'b0, 6'd10);
    queue_item(32'd1, 1'b0, BASE_BIN, 1'b0, 1'b0, 6'd63);
    queue_item(32'd1, 1'b1, BASE_BIN, 1'b1, 1'b1, 6'd63);
    queue_item(32'd511, 1'b0, BASE_OCT, 1'b1, 1'b1, 6'd63);
    queue_item(32'd9, 1'b0, BASE_DEC, 1'b0, 1'b1, 6'd63);
    queue_item(32'hffff_ff00, 1'b1, BASE_HEX, 1'b1, 1'b0, 6'd3);
    queue_item('1, 1'b0, BASE_BIN, 1'b0, 1'b1, 6'd63);
    queue_item(32'd7, 1'b0, BASE_OCT, 1'b0, 1'b1, 6'd1);
    queue_item(32'hffff_fffa, 1'b1, BASE_OCT, 1'b1, 1'b0, 6'd5);
    wait_drained();

    run_random(PHASE_ITEMS, 0, 0);
    run_random(PHASE_ITEMS, 71, 0);
    run_random(PHASE_ITEMS, 0, 71);
    run_random(PHASE_ITEMS, 31, 31);

    hold_trigger++;
    run_random(SQUEEZE_ITEMS, 0, 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    #1;
    if (mismatch_count == 0 && expected_text.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> integer_to_ascii_formatter.f
+incdir+hdl
hdl/itaf_pkg.sv
hdl/itaf_item_if.sv
hdl/itaf_text_if.sv
hdl/itaf_convert.sv
hdl/itaf_emit.sv
hdl/integer_to_ascii_formatter.sv
bench/tb_integer_to_ascii_formatter.sv
